@@ hw/rtl/debug_link_packet_transmitter_unit_assert.svh @@
// Assertion macros shared by the debug link packet transmitter.
`ifndef DEBUG_LINK_PACKET_TRANSMITTER_UNIT_ASSERT_SVH
`define DEBUG_LINK_PACKET_TRANSMITTER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Antecedent and consequent in the same cycle.
`define DLPT_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dlpt assertion failed");
// Consequent in the cycle after the antecedent.
`define DLPT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dlpt assertion failed");
`else
`define DLPT_ASSERT_NOW(lbl, clk, rst, ante, cons)
`define DLPT_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/dlpt_pkg.sv @@
`timescale 1ns / 1ps
package dlpt_pkg;

  localparam int MAX_PAYLOAD_DEF = 1024;

  // Request commands.
  localparam logic [2:0] CMD_BEGIN   = 3'd0;
  localparam logic [2:0] CMD_PAYLOAD = 3'd1;
  localparam logic [2:0] CMD_END     = 3'd2;
  localparam logic [2:0] CMD_LINK    = 3'd3;
  localparam logic [2:0] CMD_TIMEOUT = 3'd4;
  localparam logic [2:0] CMD_REPLAY  = 3'd5;

  // Result events.
  localparam logic [2:0] EV_BYTE     = 3'd0;
  localparam logic [2:0] EV_ACK      = 3'd1;
  localparam logic [2:0] EV_TIMEOUT  = 3'd2;
  localparam logic [2:0] EV_RETRY    = 3'd3;
  localparam logic [2:0] EV_OVERFLOW = 3'd4;
  localparam logic [2:0] EV_REFUSED  = 3'd5;

  // Packet kinds.
  localparam logic [1:0] KIND_PLAIN  = 2'd0;
  localparam logic [1:0] KIND_BINARY = 2'd1;
  localparam logic [1:0] KIND_NOTIFY = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_NOACK = 1'b0;
  localparam logic CFG_RETRY = 1'b1;

  localparam logic [7:0] RETRY_LIMIT_RST = 8'd4;

  // Link characters.
  localparam logic [7:0] CH_ESCAPE = 8'h7D;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] ESC_MASK  = 8'h20;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'b0001,
    PH_BUILD  = 4'b0010,
    PH_WAIT   = 4'b0100,
    PH_REPLAY = 4'b1000
  } phase_t;

  typedef enum logic [4:0] {
    SK_NONE = 5'b00001,
    SK_BODY = 5'b00010,
    SK_ESC  = 5'b00100,
    SK_SUM1 = 5'b01000,
    SK_SUM2 = 5'b10000
  } skip_t;

  typedef struct packed {
    logic [2:0] command;
    logic [7:0] data_byte;
    logic [1:0] packet_kind;
  } cmd_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] tx_byte;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic [7:0] tx_byte;
  } entry_t;

  // Up to three results caused by one request.
  typedef struct packed {
    logic [1:0]       n;
    entry_t [2:0]     e;
  } group_t;

  function automatic logic [7:0] hex_digit(input logic [3:0] d);
    if (d < 4'd10) begin
      return 8'h30 + {4'h0, d};
    end else begin
      return 8'h57 + {4'h0, d};
    end
  endfunction

  function automatic logic must_escape(input logic [7:0] b);
    return (b == CH_HASH) || (b == CH_DOLLAR) || (b == CH_ESCAPE) || (b == CH_STAR);
  endfunction

endpackage

@@ hw/rtl/dlpt_ram.sv @@
`timescale 1ns / 1ps
module dlpt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/dlpt_core.sv @@
`timescale 1ns / 1ps
module dlpt_core #(
  parameter int MAX_PAYLOAD = dlpt_pkg::MAX_PAYLOAD_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             proc,
  input  dlpt_pkg::cmd_t   item,
  input  logic             noack_mode,
  input  logic [7:0]       retry_limit,
  output logic             stale,
  output dlpt_pkg::group_t grp
);

  localparam int AW = $clog2(MAX_PAYLOAD);
  localparam int CW = $clog2(MAX_PAYLOAD + 1);
  localparam int PW = $clog2(MAX_PAYLOAD + 2);

  logic [CW-1:0]    payload_count, payload_count_next;
  logic [7:0]       running_sum, running_sum_next;
  logic [1:0]       current_kind, current_kind_next;
  dlpt_pkg::phase_t phase, phase_next;
  logic [7:0]       retries_done, retries_done_next;
  logic [PW-1:0]    replay_position, replay_position_next;
  dlpt_pkg::skip_t  skip_state, skip_state_next;
  logic             upd;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic [7:0]       rdata;
  logic [7:0]       pay;
  logic [7:0]       esc;
  logic             do_esc;

  // The store is read every cycle at the current replay slot.
  assign raddr = (replay_position == '0) ? '0 : AW'(replay_position - 1'b1);
  assign waddr = AW'(payload_count);
  // Data read in the cycle after a state update belongs to the old slot.
  assign stale = upd;

  dlpt_ram #(
    .WIDTH(8),
    .DEPTH(MAX_PAYLOAD)
  ) u_store (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(item.data_byte),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    payload_count_next   = payload_count;
    running_sum_next     = running_sum;
    current_kind_next    = current_kind;
    phase_next           = phase;
    retries_done_next    = retries_done;
    replay_position_next = replay_position;
    skip_state_next      = skip_state;
    we                   = 1'b0;
    grp                  = '0;
    pay = (item.command == dlpt_pkg::CMD_REPLAY) ? rdata : item.data_byte;
    esc = pay ^ dlpt_pkg::ESC_MASK;
    do_esc = (current_kind == dlpt_pkg::KIND_BINARY) && dlpt_pkg::must_escape(pay);

    if (item.command == dlpt_pkg::CMD_BEGIN &&
        (phase == dlpt_pkg::PH_IDLE || phase == dlpt_pkg::PH_BUILD) &&
        item.packet_kind != 2'd3) begin
      current_kind_next  = item.packet_kind;
      payload_count_next = '0;
      running_sum_next   = '0;
      phase_next         = dlpt_pkg::PH_BUILD;
      grp.n = 2'd1;
      grp.e[0] = '{dlpt_pkg::EV_BYTE, (item.packet_kind == dlpt_pkg::KIND_NOTIFY) ?
                   dlpt_pkg::CH_PCT : dlpt_pkg::CH_DOLLAR};
    end else if (item.command == dlpt_pkg::CMD_PAYLOAD && phase == dlpt_pkg::PH_BUILD) begin
      if (payload_count >= CW'(MAX_PAYLOAD)) begin
        grp.n = 2'd1;
        grp.e[0] = '{dlpt_pkg::EV_OVERFLOW, 8'h00};
      end else begin
        we = proc;
        payload_count_next = payload_count + 1'b1;
        if (do_esc) begin
          grp.n = 2'd2;
          grp.e[0] = '{dlpt_pkg::EV_BYTE, dlpt_pkg::CH_ESCAPE};
          grp.e[1] = '{dlpt_pkg::EV_BYTE, esc};
          running_sum_next = running_sum + dlpt_pkg::CH_ESCAPE + esc;
        end else begin
          grp.n = 2'd1;
          grp.e[0] = '{dlpt_pkg::EV_BYTE, pay};
          running_sum_next = running_sum + pay;
        end
      end
    end else if (item.command == dlpt_pkg::CMD_END && phase == dlpt_pkg::PH_BUILD) begin
      grp.n = 2'd3;
      grp.e[0] = '{dlpt_pkg::EV_BYTE, dlpt_pkg::CH_HASH};
      grp.e[1] = '{dlpt_pkg::EV_BYTE, dlpt_pkg::hex_digit(running_sum[7:4])};
      grp.e[2] = '{dlpt_pkg::EV_BYTE, dlpt_pkg::hex_digit(running_sum[3:0])};
      if (current_kind == dlpt_pkg::KIND_NOTIFY || noack_mode) begin
        phase_next = dlpt_pkg::PH_IDLE;
      end else begin
        phase_next        = dlpt_pkg::PH_WAIT;
        retries_done_next = '0;
        skip_state_next   = dlpt_pkg::SK_NONE;
      end
    end else if (item.command == dlpt_pkg::CMD_LINK && phase == dlpt_pkg::PH_WAIT) begin
      case (skip_state)
        dlpt_pkg::SK_BODY: begin
          if (pay == dlpt_pkg::CH_HASH) begin
            skip_state_next = dlpt_pkg::SK_SUM1;
          end else if (pay == dlpt_pkg::CH_ESCAPE) begin
            skip_state_next = dlpt_pkg::SK_ESC;
          end
        end
        dlpt_pkg::SK_ESC:  skip_state_next = dlpt_pkg::SK_BODY;
        dlpt_pkg::SK_SUM1: skip_state_next = dlpt_pkg::SK_SUM2;
        dlpt_pkg::SK_SUM2: skip_state_next = dlpt_pkg::SK_NONE;
        default: begin
          skip_state_next = dlpt_pkg::SK_NONE;
          if (pay == dlpt_pkg::CH_PLUS) begin
            grp.n = 2'd1;
            grp.e[0] = '{dlpt_pkg::EV_ACK, 8'h00};
            phase_next = dlpt_pkg::PH_IDLE;
          end else if (pay == dlpt_pkg::CH_MINUS) begin
            if (retries_done >= retry_limit) begin
              grp.n = 2'd1;
              grp.e[0] = '{dlpt_pkg::EV_RETRY, 8'h00};
              phase_next = dlpt_pkg::PH_IDLE;
            end else begin
              retries_done_next    = retries_done + 1'b1;
              replay_position_next = '0;
              phase_next           = dlpt_pkg::PH_REPLAY;
            end
          end else if (pay == dlpt_pkg::CH_DOLLAR) begin
            skip_state_next = dlpt_pkg::SK_BODY;
          end
        end
      endcase
    end else if (item.command == dlpt_pkg::CMD_TIMEOUT && phase == dlpt_pkg::PH_WAIT) begin
      grp.n = 2'd1;
      grp.e[0] = '{dlpt_pkg::EV_TIMEOUT, 8'h00};
      phase_next      = dlpt_pkg::PH_IDLE;
      skip_state_next = dlpt_pkg::SK_NONE;
    end else if (item.command == dlpt_pkg::CMD_REPLAY && phase == dlpt_pkg::PH_REPLAY) begin
      if (replay_position == '0) begin
        grp.n = 2'd1;
        grp.e[0] = '{dlpt_pkg::EV_BYTE, dlpt_pkg::CH_DOLLAR};
        replay_position_next = PW'(1);
      end else if (replay_position <= PW'(payload_count)) begin
        replay_position_next = replay_position + 1'b1;
        if (do_esc) begin
          grp.n = 2'd2;
          grp.e[0] = '{dlpt_pkg::EV_BYTE, dlpt_pkg::CH_ESCAPE};
          grp.e[1] = '{dlpt_pkg::EV_BYTE, esc};
        end else begin
          grp.n = 2'd1;
          grp.e[0] = '{dlpt_pkg::EV_BYTE, pay};
        end
      end else begin
        grp.n = 2'd3;
        grp.e[0] = '{dlpt_pkg::EV_BYTE, dlpt_pkg::CH_HASH};
        grp.e[1] = '{dlpt_pkg::EV_BYTE, dlpt_pkg::hex_digit(running_sum[7:4])};
        grp.e[2] = '{dlpt_pkg::EV_BYTE, dlpt_pkg::hex_digit(running_sum[3:0])};
        phase_next           = dlpt_pkg::PH_WAIT;
        skip_state_next      = dlpt_pkg::SK_NONE;
        replay_position_next = '0;
      end
    end else begin
      grp.n = 2'd1;
      grp.e[0] = '{dlpt_pkg::EV_REFUSED, 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_count   <= '0;
      running_sum     <= '0;
      current_kind    <= '0;
      phase           <= dlpt_pkg::PH_IDLE;
      retries_done    <= '0;
      replay_position <= '0;
      skip_state      <= dlpt_pkg::SK_NONE;
      upd             <= 1'b0;
    end else begin
      upd <= proc;
      if (proc) begin
        payload_count   <= payload_count_next;
        running_sum     <= running_sum_next;
        current_kind    <= current_kind_next;
        phase           <= phase_next;
        retries_done    <= retries_done_next;
        replay_position <= replay_position_next;
        skip_state      <= skip_state_next;
      end
    end
  end

endmodule

@@ hw/rtl/dlpt_emit.sv @@
`timescale 1ns / 1ps
module dlpt_emit (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  dlpt_pkg::group_t grp_in,
  output logic             free,
  output logic             res_valid,
  input  logic             res_stall,
  output dlpt_pkg::res_t   res
);

  dlpt_pkg::group_t grp;
  logic [1:0]       idx;
  logic             busy;
  logic             take;
  logic             last_now;

  assign take      = busy && !res_stall;
  assign last_now  = (idx == grp.n - 2'd1);
  assign free      = !busy || (take && last_now);
  assign res_valid = busy;
  assign res       = '{grp.e[idx].event_res, grp.e[idx].tx_byte, last_now};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load && grp_in.n != 2'd0) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (take) begin
      if (last_now) begin
        busy <= 1'b0;
      end else begin
        idx <= idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp <= grp_in;
    end
  end

endmodule

@@ hw/rtl/debug_link_packet_transmitter_unit.sv @@
`timescale 1ns / 1ps
`include "debug_link_packet_transmitter_unit_assert.svh"
// Debug link packet transmitter: frames outgoing debug packets and tracks the
// partner's acknowledge. Requests arrive on the cmd channel (cmd_valid,
// cmd_stall, cmd) and results leave on the res channel (res_valid, res_stall,
// res); each request gives zero to three results, the final one marked last.
// The two configuration registers (no-ack mode, retry limit) are written over
// cfg_valid/cfg_ready, which is always ready; write them only while idle.
// A request is held in an input register and handled once the store data is
// fresh and the result buffer is free; its group is registered in the result
// buffer, from which results leave one per cycle while the receiver does not
// stall. The next request can be handled in the cycle in which the last result
// of the previous one is taken.
// The payload store is a single-port-write memory read through a register at
// the replay slot; after a request is handled, the next one waits for fresh
// read data, so two requests are never handled back to back.
// Synchronous reset returns to idle with no packet open and the retry limit
// at four; the store is not cleared. While the receiver stalls, the current
// result holds and, once the input register is occupied, cmd_stall rises.
module debug_link_packet_transmitter_unit #(
  parameter int MAX_PAYLOAD = dlpt_pkg::MAX_PAYLOAD_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           cmd_valid,
  output logic           cmd_stall,
  input  dlpt_pkg::cmd_t cmd,
  output logic           res_valid,
  input  logic           res_stall,
  output dlpt_pkg::res_t res,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic           cfg_index,
  input  logic [7:0]     cfg_data
);

  dlpt_pkg::cmd_t   item;
  logic             item_full;
  logic             noack_mode;
  logic [7:0]       retry_limit;
  logic             stale;
  logic             free;
  logic             proc;
  dlpt_pkg::group_t grp;

  // A held request is handled once the result buffer can take its group and
  // the store read data matches the current state.
  assign proc      = item_full && !stale && free;
  assign cmd_stall = item_full && !proc;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (cmd_valid && !cmd_stall) begin
      item_full <= 1'b1;
    end else if (proc) begin
      item_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_valid && !cmd_stall) begin
      item <= cmd;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      noack_mode  <= 1'b0;
      retry_limit <= dlpt_pkg::RETRY_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dlpt_pkg::CFG_NOACK: noack_mode  <= cfg_data[0];
        dlpt_pkg::CFG_RETRY: retry_limit <= cfg_data;
        default: ;
      endcase
    end
  end

  dlpt_core #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_core (
    .clk        (clk),
    .rst        (rst),
    .proc       (proc),
    .item       (item),
    .noack_mode (noack_mode),
    .retry_limit(retry_limit),
    .stale      (stale),
    .grp        (grp)
  );

  dlpt_emit u_emit (
    .clk      (clk),
    .rst      (rst),
    .load     (proc),
    .grp_in   (grp),
    .free     (free),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res      (res)
  );

  // A request that yields results must put the first one out next cycle.
  `DLPT_ASSERT_NEXT(a_group_shown, clk, rst, proc && grp.n != 2'd0, res_valid)
  // The input side stalls only while a request is held.
  `DLPT_ASSERT_NOW(a_stall_held, clk, rst, !item_full, !cmd_stall)
  // Two requests are never handled in consecutive cycles (read interlock).
  `DLPT_ASSERT_NEXT(a_interlock, clk, rst, proc, !proc)
  // Nothing is shown straight after reset.
  `DLPT_ASSERT_NOW(a_reset_quiet, clk, 1'b0, $past(rst), !res_valid)

endmodule
